/* hdl/tscu_pkg.sv */
// ----------------------------------------------------------------------------
// tscu_pkg
// Shared types and constants for the tolerant site clustering unit.
// ----------------------------------------------------------------------------
package tscu_pkg;

    localparam int POS_W   = 32;
    localparam int TOL_W   = 16;
    localparam int COUNT_W = 7;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_DONE
    } tscu_state_t;

    typedef enum logic {
        TBL_START,
        TBL_END
    } tscu_tbl_t;

    typedef struct packed {
        logic               start_added;
        logic               end_added;
        logic [COUNT_W-1:0] start_count;
        logic [COUNT_W-1:0] end_count;
        logic               start_full;
        logic               end_full;
    } tscu_result_t;

endpackage

/* hdl/tolerant_site_clustering_unit.sv */
// ----------------------------------------------------------------------------
// tolerant_site_clustering_unit
// Clusters transcript start and end positions into sites within a tolerance.
// ----------------------------------------------------------------------------
// Each request carries one transcript's start and end position. Two site
// tables (MAX_SITES entries each) are scanned one after the other through a
// single distance unit, one stored site per cycle; a position within the
// tolerance register of any stored site merges, otherwise it is appended,
// or dropped with the full flag when its table is at capacity. A request
// is processed one at a time, and its latency grows with the start and end
// sites stored before it; the sequential walk of the site memories through
// the shared distance unit sets that latency. A new request is taken once
// the previous result has moved into the output register.
module tolerant_site_clustering_unit
    import tscu_pkg::*;
#(
    parameter int MAX_SITES = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [TOL_W-1:0]   cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_first_of_group,
    input  logic [POS_W-1:0]   s_start_pos,
    input  logic [POS_W-1:0]   s_end_pos,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_start_added,
    output logic               m_end_added,
    output logic [COUNT_W-1:0] m_start_count,
    output logic [COUNT_W-1:0] m_end_count,
    output logic               m_start_full,
    output logic               m_end_full
);

    localparam int CNT_W  = $clog2(MAX_SITES + 1);
    localparam int ADDR_W = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;

    logic [TOL_W-1:0]  tol_reg;
    logic              m_valid_reg;
    tscu_result_t      out_reg;
    logic              out_free;
    logic              res_valid;
    tscu_result_t      res;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [POS_W-1:0]  wr_data;
    logic [POS_W-1:0]  start_rd_data;
    logic [POS_W-1:0]  end_rd_data;
    logic              start_we;
    logic              end_we;
    logic              dist_load;
    logic [POS_W-1:0]  dist_site;
    logic [POS_W-1:0]  dist_pos;
    logic              dist_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (cfg_wr_en) begin
            tol_reg <= cfg_wr_data;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    tscu_ctrl #(
        .MAX_SITES (MAX_SITES),
        .CNT_W     (CNT_W),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_first_of_group (s_first_of_group),
        .s_start_pos      (s_start_pos),
        .s_end_pos        (s_end_pos),
        .out_free         (out_free),
        .res_valid        (res_valid),
        .res              (res),
        .rd_addr          (rd_addr),
        .start_rd_data    (start_rd_data),
        .end_rd_data      (end_rd_data),
        .start_we         (start_we),
        .end_we           (end_we),
        .wr_addr          (wr_addr),
        .wr_data          (wr_data),
        .dist_load        (dist_load),
        .dist_site        (dist_site),
        .dist_pos         (dist_pos),
        .dist_hit         (dist_hit)
    );

    tscu_site_mem #(
        .DEPTH  (MAX_SITES),
        .ADDR_W (ADDR_W)
    ) u_start_mem (
        .aclk    (aclk),
        .wr_en   (start_we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (start_rd_data)
    );

    tscu_site_mem #(
        .DEPTH  (MAX_SITES),
        .ADDR_W (ADDR_W)
    ) u_end_mem (
        .aclk    (aclk),
        .wr_en   (end_we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (end_rd_data)
    );

    tscu_dist_unit u_dist (
        .aclk (aclk),
        .load (dist_load),
        .site (dist_site),
        .pos  (dist_pos),
        .tol  (tol_reg),
        .hit  (dist_hit)
    );

    assign m_valid       = m_valid_reg;
    assign m_start_added = out_reg.start_added;
    assign m_end_added   = out_reg.end_added;
    assign m_start_count = out_reg.start_count;
    assign m_end_count   = out_reg.end_count;
    assign m_start_full  = out_reg.start_full;
    assign m_end_full    = out_reg.end_full;

endmodule

/* hdl/tscu_site_mem.sv */
// ----------------------------------------------------------------------------
// tscu_site_mem
// Site table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tscu_site_mem
    import tscu_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [POS_W-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [POS_W-1:0]  rd_data
);

    logic [POS_W-1:0] mem [DEPTH];
    logic [POS_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/tscu_dist_unit.sv */
// ----------------------------------------------------------------------------
// tscu_dist_unit
// Shared distance unit: absolute difference registered, then tolerance check.
// ----------------------------------------------------------------------------
module tscu_dist_unit
    import tscu_pkg::*;
(
    input  logic             aclk,
    input  logic             load,
    input  logic [POS_W-1:0] site,
    input  logic [POS_W-1:0] pos,
    input  logic [TOL_W-1:0] tol,
    output logic             hit
);

    logic [POS_W-1:0] dist_reg;
    logic [POS_W-1:0] dist_next;

    always_comb begin
        if (site >= pos) begin
            dist_next = site - pos;
        end else begin
            dist_next = pos - site;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            dist_reg <= dist_next;
        end
    end

    // Distance equal to tolerance still merges.
    assign hit = (dist_reg <= POS_W'(tol));

endmodule

/* hdl/tscu_ctrl.sv */
// ----------------------------------------------------------------------------
// tscu_ctrl
// Sequencer: scans each site table through the distance unit, then appends.
// ----------------------------------------------------------------------------
module tscu_ctrl
    import tscu_pkg::*;
#(
    parameter int MAX_SITES = 64,
    parameter int CNT_W     = 7,
    parameter int ADDR_W    = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_first_of_group,
    input  logic [POS_W-1:0]  s_start_pos,
    input  logic [POS_W-1:0]  s_end_pos,
    input  logic              out_free,
    output logic              res_valid,
    output tscu_result_t      res,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [POS_W-1:0]  start_rd_data,
    input  logic [POS_W-1:0]  end_rd_data,
    output logic              start_we,
    output logic              end_we,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [POS_W-1:0]  wr_data,
    output logic              dist_load,
    output logic [POS_W-1:0]  dist_site,
    output logic [POS_W-1:0]  dist_pos,
    input  logic              dist_hit
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_SITES);

    tscu_state_t      state_reg, state_next;
    tscu_tbl_t        tsel_reg, tsel_next;
    logic [CNT_W-1:0] start_fill_reg, start_fill_next;
    logic [CNT_W-1:0] end_fill_reg, end_fill_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             cmp_pend_reg;
    logic             merged_reg, merged_next;
    logic             start_added_reg, start_added_next;
    logic             end_added_reg, end_added_next;
    logic             start_full_reg, start_full_next;
    logic             end_full_reg, end_full_next;
    logic [POS_W-1:0] spos_reg, epos_reg;
    logic [CNT_W-1:0] cur_fill;
    logic             is_new;
    logic             tbl_full;
    logic             accept;

    assign accept    = s_valid && s_ready;
    assign cur_fill  = (tsel_reg == TBL_START) ? start_fill_reg : end_fill_reg;
    assign is_new    = !merged_reg;
    assign tbl_full  = (cur_fill == FULL_CNT);
    assign dist_pos  = (tsel_reg == TBL_START) ? spos_reg : epos_reg;
    assign dist_site = (tsel_reg == TBL_START) ? start_rd_data : end_rd_data;
    assign dist_load = rd_pend_reg;
    assign rd_addr   = idx_reg[ADDR_W-1:0];
    assign wr_addr   = cur_fill[ADDR_W-1:0];
    assign wr_data   = dist_pos;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            tsel_reg        <= TBL_START;
            start_fill_reg  <= '0;
            end_fill_reg    <= '0;
            idx_reg         <= '0;
            rd_pend_reg     <= 1'b0;
            cmp_pend_reg    <= 1'b0;
            merged_reg      <= 1'b0;
            start_added_reg <= 1'b0;
            end_added_reg   <= 1'b0;
            start_full_reg  <= 1'b0;
            end_full_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            tsel_reg        <= tsel_next;
            start_fill_reg  <= start_fill_next;
            end_fill_reg    <= end_fill_next;
            idx_reg         <= idx_next;
            rd_pend_reg     <= rd_pend_next;
            cmp_pend_reg    <= rd_pend_reg;
            merged_reg      <= merged_next;
            start_added_reg <= start_added_next;
            end_added_reg   <= end_added_next;
            start_full_reg  <= start_full_next;
            end_full_reg    <= end_full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            spos_reg <= s_start_pos;
            epos_reg <= s_end_pos;
        end
    end

    always_comb begin
        state_next       = state_reg;
        tsel_next        = tsel_reg;
        start_fill_next  = start_fill_reg;
        end_fill_next    = end_fill_reg;
        idx_next         = idx_reg;
        rd_pend_next     = 1'b0;
        merged_next      = merged_reg;
        start_added_next = start_added_reg;
        end_added_next   = end_added_reg;
        start_full_next  = start_full_reg;
        end_full_next    = end_full_reg;
        s_ready          = 1'b0;
        res_valid        = 1'b0;
        start_we         = 1'b0;
        end_we           = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    // A new group empties both tables first.
                    if (s_first_of_group) begin
                        start_fill_next = '0;
                        end_fill_next   = '0;
                    end
                    tsel_next        = TBL_START;
                    idx_next         = '0;
                    merged_next      = 1'b0;
                    start_added_next = 1'b0;
                    end_added_next   = 1'b0;
                    start_full_next  = 1'b0;
                    end_full_next    = 1'b0;
                    state_next       = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cmp_pend_reg && dist_hit) begin
                    merged_next = 1'b1;
                end
                if (idx_reg < cur_fill) begin
                    rd_pend_next = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                end else if (!rd_pend_reg && !cmp_pend_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (tsel_reg == TBL_START) begin
                    start_full_next  = is_new && tbl_full;
                    start_added_next = is_new && !tbl_full;
                    if (is_new && !tbl_full) begin
                        start_we        = 1'b1;
                        start_fill_next = start_fill_reg + 1'b1;
                    end
                    tsel_next   = TBL_END;
                    idx_next    = '0;
                    merged_next = 1'b0;
                    state_next  = ST_SCAN;
                end else begin
                    end_full_next  = is_new && tbl_full;
                    end_added_next = is_new && !tbl_full;
                    if (is_new && !tbl_full) begin
                        end_we        = 1'b1;
                        end_fill_next = end_fill_reg + 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register can take the result.
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res.start_added = start_added_reg;
        res.end_added   = end_added_reg;
        res.start_count = COUNT_W'(start_fill_reg);
        res.end_count   = COUNT_W'(end_fill_reg);
        res.start_full  = start_full_reg;
        res.end_full    = end_full_reg;
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (start_fill_reg <= FULL_CNT) && (end_fill_reg <= FULL_CNT))
        else $error("site count above table capacity");

    a_append_count: assert property (@(posedge aclk) disable iff (!aresetn)
        start_we |=> (start_fill_reg == CNT_W'($past(start_fill_reg) + 1'b1)))
        else $error("start table append did not advance count");

    a_read_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |=> cmp_pend_reg)
        else $error("read data not passed to distance unit");

    a_decide_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE) |-> (!rd_pend_reg && !cmp_pend_reg))
        else $error("decision taken with compares still in flight");

    a_no_write_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (start_we || end_we) |-> !tbl_full)
        else $error("append into a full table");

endmodule
